// File: src/kmd_pkg.sv
package kmd_pkg;

	localparam int ROWS_DEF = 4;
	localparam int COLS_DEF = 4;

	localparam int ROW_W   = 2;
	localparam int COL_W   = 2;
	localparam int SLOT_W  = ROW_W + COL_W;
	localparam int SLOTS   = 1 << SLOT_W;
	localparam int KEYNUM_W = 5;
	localparam int TICK_W  = 32;
	localparam int HIST_W  = 8;
	localparam int LOCK_W  = 8;

	localparam logic [LOCK_W-1:0] LOCKOUT_RESET = LOCK_W'(5);
	localparam logic [HIST_W-1:0] HIST_RELEASED = 8'h00;
	localparam logic [HIST_W-1:0] HIST_PRESSED  = 8'hFF;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		EV_PRESS   = 1'b0,
		EV_RELEASE = 1'b1
	} event_kind_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [KEYNUM_W-1:0] key_number;
		logic                level;
		logic [TICK_W-1:0]   now_tick;
	} sample_t;

endpackage

// File: src/kmd_sample_if.sv
interface kmd_sample_if;
	logic                          valid;
	logic                          ready;
	logic [kmd_pkg::ROW_W-1:0]     row_index;
	logic [kmd_pkg::COL_W-1:0]     col_index;
	logic                          level;
	logic [kmd_pkg::TICK_W-1:0]    now_tick;

	modport source (output valid, row_index, col_index, level, now_tick, input ready);
	modport sink (input valid, row_index, col_index, level, now_tick, output ready);
endinterface

// File: src/kmd_event_if.sv
interface kmd_event_if;
	logic                          valid;
	logic                          ready;
	logic [kmd_pkg::KEYNUM_W-1:0]  key_number;
	logic                          event_kind;

	modport source (output valid, key_number, event_kind, input ready);
	modport sink (input valid, key_number, event_kind, output ready);
endinterface

// File: src/kmd_cfg_if.sv
interface kmd_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [kmd_pkg::LOCK_W-1:0]   lockout_ticks;

	modport source (output valid, lockout_ticks, input ready);
	modport sink (input valid, lockout_ticks, output ready);
endinterface

// File: src/kmd_front.sv
module kmd_front #(
	parameter int ROWS = kmd_pkg::ROWS_DEF,
	parameter int COLS = kmd_pkg::COLS_DEF
) (
	kmd_sample_if.sink       samples,
	input  logic             q_full,
	output logic             push,
	output kmd_pkg::sample_t push_data
);

	localparam int DIM_W = $clog2(16 + 1);
	localparam int NUM_W = 8;

	logic             in_range;
	logic [NUM_W-1:0] num_full;

	assign samples.ready = !q_full;

	assign in_range = ({{(DIM_W - kmd_pkg::ROW_W){1'b0}}, samples.row_index} < DIM_W'(ROWS))
		&& ({{(DIM_W - kmd_pkg::COL_W){1'b0}}, samples.col_index} < DIM_W'(COLS));

	assign num_full = {{(NUM_W - kmd_pkg::ROW_W){1'b0}}, samples.row_index} * NUM_W'(COLS)
		+ {{(NUM_W - kmd_pkg::COL_W){1'b0}}, samples.col_index} + NUM_W'(1);

	assign push = samples.valid && samples.ready && in_range;

	always_comb begin
		push_data.slot       = {samples.row_index, samples.col_index};
		push_data.key_number = num_full[kmd_pkg::KEYNUM_W-1:0];
		push_data.level      = samples.level;
		push_data.now_tick   = samples.now_tick;
	end

endmodule

// File: src/kmd_queue.sv
module kmd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kmd_pkg::sample_t push_data,
	output logic             full,
	output logic             q_valid,
	input  logic             pop,
	output kmd_pkg::sample_t q_data
);

	localparam int AW = (kmd_pkg::QUEUE_AW > 0) ? kmd_pkg::QUEUE_AW : 1;

	kmd_pkg::sample_t     mem_q [kmd_pkg::QUEUE_DEPTH];
	logic [AW-1:0]        wr_ptr_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [AW:0]          count_q;

	assign full    = (count_q == (AW+1)'(kmd_pkg::QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(kmd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(kmd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/kmd_back.sv
module kmd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  kmd_pkg::sample_t q_data,
	output logic             pop,
	kmd_cfg_if.sink          cfg,
	kmd_event_if.source      events
);

	logic [kmd_pkg::HIST_W-1:0]  hist_q    [kmd_pkg::SLOTS];
	logic                        pressed_q [kmd_pkg::SLOTS];
	logic [kmd_pkg::TICK_W-1:0]  stamp_q   [kmd_pkg::SLOTS];
	logic [kmd_pkg::LOCK_W-1:0]  lockout_q;

	logic                        out_valid_q;
	logic [kmd_pkg::KEYNUM_W-1:0] out_num_q;
	kmd_pkg::event_kind_t        out_kind_q;

	logic [kmd_pkg::HIST_W-1:0]  hist_nx;
	logic [kmd_pkg::TICK_W-1:0]  elapsed;
	logic                        passed;
	logic                        is_press;
	logic                        is_release;

	assign cfg.ready = 1'b1;

	assign pop = q_valid && (!out_valid_q || events.ready);

	assign hist_nx    = {hist_q[q_data.slot][kmd_pkg::HIST_W-2:0], q_data.level};
	assign elapsed    = q_data.now_tick - stamp_q[q_data.slot];
	assign passed     = elapsed > {{(kmd_pkg::TICK_W - kmd_pkg::LOCK_W){1'b0}}, lockout_q};
	assign is_press   = (hist_nx == kmd_pkg::HIST_RELEASED) && !pressed_q[q_data.slot] && passed;
	assign is_release = (hist_nx == kmd_pkg::HIST_PRESSED) && pressed_q[q_data.slot] && passed;

	assign events.valid      = out_valid_q;
	assign events.key_number = out_num_q;
	assign events.event_kind = out_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kmd_pkg::SLOTS; i++) begin
				hist_q[i]    <= '0;
				pressed_q[i] <= 1'b0;
				stamp_q[i]   <= '0;
			end
			lockout_q   <= kmd_pkg::LOCKOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				lockout_q <= cfg.lockout_ticks;
			end
			if (pop) begin
				hist_q[q_data.slot] <= hist_nx;
				if (is_press) begin
					pressed_q[q_data.slot] <= 1'b1;
					stamp_q[q_data.slot]   <= q_data.now_tick;
				end else if (is_release) begin
					pressed_q[q_data.slot] <= 1'b0;
				end
				out_valid_q <= is_press || is_release;
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_num_q  <= q_data.key_number;
			out_kind_q <= is_release ? kmd_pkg::EV_RELEASE : kmd_pkg::EV_PRESS;
		end
	end

endmodule

// File: src/key_matrix_debouncer.sv
// Key matrix debouncer: one sampled level per transfer on samples (row, column,
// active-low level, millisecond tick); press/release events leave on events.
// The lockout register is written through cfg, which is always ready; write it
// only while no sample is in flight.
// Samples outside the ROWS x COLS matrix are taken and dropped.
// A sample is first written into the queue; the back end then registers its
// event in the output register, which drives events.valid.
// Throughput: one sample per cycle while events is ready; the per-key history,
// state and timestamp update is a read-modify-write in the back end.
// A two-entry queue sits between the front end and the back end; when events
// stalls, the held event waits in the output register, the queue fills and
// samples.ready drops once it is full.
// Reset clears every key's history, debounced state and timestamp, empties the
// queue and output register and sets the lockout to 5 ticks.
module key_matrix_debouncer #(
	parameter int ROWS = kmd_pkg::ROWS_DEF,
	parameter int COLS = kmd_pkg::COLS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	kmd_sample_if.sink   samples,
	kmd_event_if.source  events,
	kmd_cfg_if.sink      cfg
);

	logic             push;
	logic             full;
	logic             q_valid;
	logic             pop;
	kmd_pkg::sample_t push_data;
	kmd_pkg::sample_t q_data;

	kmd_front #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_front (
		.samples   (samples),
		.q_full    (full),
		.push      (push),
		.push_data (push_data)
	);

	kmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.q_valid   (q_valid),
		.pop       (pop),
		.q_data    (q_data)
	);

	kmd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.pop     (pop),
		.cfg     (cfg),
		.events  (events)
	);

endmodule
